### rtl/core/rpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_pkg
// Shared types, constants and a helper function of the rho factoring unit.
// ----------------------------------------------------------------------------
package rpf_pkg;

    localparam int WORD_BITS = 64;
    localparam int DIVD_W    = (WORD_BITS > 31) ? WORD_BITS : 31;
    localparam int DCNT_W    = $clog2(DIVD_W);
    localparam int GEN_W     = 48;
    localparam int GEN_MUL_W = 35;
    localparam int GCNT_W    = 6;

    localparam logic [GEN_MUL_W-1:0] GEN_MUL  = 35'h5_DEEC_E66D;
    localparam logic [GEN_W-1:0]     GEN_ADD  = 48'hB;
    localparam logic [15:0]          GEN_LOW  = 16'h330E;
    localparam logic [GEN_W-1:0]     GEN_RST  = 48'h1234_ABCD_330E;
    localparam logic [31:0]          LIMIT_RST = 32'd16777216;
    localparam logic [GCNT_W-1:0]    GEN_LAST = GCNT_W'(GEN_MUL_W - 1);
    localparam logic [DCNT_W-1:0]    DIV_LAST = DCNT_W'(DIVD_W - 1);

    localparam logic [1:0] CFG_STEP_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_RANDOM_SEED = 2'd1;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_CAPPED = 2'd1;
    localparam logic [1:0] STATUS_RANGE  = 2'd2;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_LCG_START,
        CMD_LCG_RUN,
        CMD_DIV_Q,
        CMD_DIV_X,
        CMD_DIV_GCD,
        CMD_DIV_FAC,
        CMD_DIV_RUN,
        CMD_SET_Q,
        CMD_SET_X,
        CMD_MAP_START,
        CMD_MAP_RUN,
        CMD_DIFF,
        CMD_GCD_SWAP,
        CMD_ADVANCE,
        CMD_RESULT_SMALL,
        CMD_RESULT_CAP,
        CMD_RESULT_FAC
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SIZE,
        ST_DRAW_Q_START,
        ST_DRAW_Q_RUN,
        ST_DIV_Q_START,
        ST_DIV_Q_RUN,
        ST_SET_Q,
        ST_DRAW_X_START,
        ST_DRAW_X_RUN,
        ST_DIV_X_START,
        ST_DIV_X_RUN,
        ST_SET_X,
        ST_CHECK,
        ST_MAP_RUN,
        ST_DIFF,
        ST_GCD_CHECK,
        ST_GCD_DIV_START,
        ST_GCD_DIV_RUN,
        ST_GCD_SWAP,
        ST_EVAL,
        ST_FAC_DIV_START,
        ST_FAC_DIV_RUN,
        ST_FIN_SMALL,
        ST_FIN_CAP,
        ST_FIN_FAC
    } state_t;

    typedef struct packed {
        logic n_small;
        logic lcg_last;
        logic div_last;
        logic map_done;
        logic capped;
        logic gcd_b_zero;
        logic g_is_one;
        logic g_lt_n;
        logic out_busy;
    } dp_status_t;

    function automatic logic [WORD_BITS-1:0] add_mod(
        input logic [WORD_BITS-1:0] a,
        input logic [WORD_BITS-1:0] b,
        input logic [WORD_BITS-1:0] n
    );
        logic [WORD_BITS-1:0] room;
        room = n - b;
        return (a >= room) ? (a - room) : (a + b);
    endfunction

endpackage

### rtl/core/rpf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_ctrl
// Sequencer of the rho factoring unit: draws, rho steps, gcd and result.
// ----------------------------------------------------------------------------
module rpf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rpf_pkg::dp_status_t status,
    output rpf_pkg::cmd_t      cmd
);
    import rpf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:          if (s_valid) state_next = ST_SIZE;
            ST_SIZE:          state_next = status.n_small ? ST_FIN_SMALL : ST_DRAW_Q_START;
            ST_DRAW_Q_START:  state_next = ST_DRAW_Q_RUN;
            ST_DRAW_Q_RUN:    if (status.lcg_last) state_next = ST_DIV_Q_START;
            ST_DIV_Q_START:   state_next = ST_DIV_Q_RUN;
            ST_DIV_Q_RUN:     if (status.div_last) state_next = ST_SET_Q;
            ST_SET_Q:         state_next = ST_DRAW_X_START;
            ST_DRAW_X_START:  state_next = ST_DRAW_X_RUN;
            ST_DRAW_X_RUN:    if (status.lcg_last) state_next = ST_DIV_X_START;
            ST_DIV_X_START:   state_next = ST_DIV_X_RUN;
            ST_DIV_X_RUN:     if (status.div_last) state_next = ST_SET_X;
            ST_SET_X:         state_next = ST_CHECK;
            ST_CHECK:         state_next = status.capped ? ST_FIN_CAP : ST_MAP_RUN;
            ST_MAP_RUN:       if (status.map_done) state_next = ST_DIFF;
            ST_DIFF:          state_next = ST_GCD_CHECK;
            ST_GCD_CHECK:     state_next = status.gcd_b_zero ? ST_EVAL : ST_GCD_DIV_START;
            ST_GCD_DIV_START: state_next = ST_GCD_DIV_RUN;
            ST_GCD_DIV_RUN:   if (status.div_last) state_next = ST_GCD_SWAP;
            ST_GCD_SWAP:      state_next = ST_GCD_CHECK;
            ST_EVAL: begin
                if (status.g_is_one) begin
                    state_next = ST_CHECK;
                end else if (status.g_lt_n) begin
                    state_next = ST_FAC_DIV_START;
                end else begin
                    state_next = ST_DRAW_Q_START;
                end
            end
            ST_FAC_DIV_START: state_next = ST_FAC_DIV_RUN;
            ST_FAC_DIV_RUN:   if (status.div_last) state_next = ST_FIN_FAC;
            ST_FIN_SMALL,
            ST_FIN_CAP,
            ST_FIN_FAC:       if (!status.out_busy) state_next = ST_IDLE;
            default:          state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = CMD_NONE;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd = CMD_LOAD;
            end
            ST_DRAW_Q_START,
            ST_DRAW_X_START:  cmd = CMD_LCG_START;
            ST_DRAW_Q_RUN,
            ST_DRAW_X_RUN:    cmd = CMD_LCG_RUN;
            ST_DIV_Q_START:   cmd = CMD_DIV_Q;
            ST_DIV_X_START:   cmd = CMD_DIV_X;
            ST_GCD_DIV_START: cmd = CMD_DIV_GCD;
            ST_FAC_DIV_START: cmd = CMD_DIV_FAC;
            ST_DIV_Q_RUN,
            ST_DIV_X_RUN,
            ST_GCD_DIV_RUN,
            ST_FAC_DIV_RUN:   cmd = CMD_DIV_RUN;
            ST_SET_Q:         cmd = CMD_SET_Q;
            ST_SET_X:         cmd = CMD_SET_X;
            ST_CHECK:         if (!status.capped) cmd = CMD_MAP_START;
            ST_MAP_RUN:       cmd = CMD_MAP_RUN;
            ST_DIFF:          cmd = CMD_DIFF;
            ST_GCD_SWAP:      cmd = CMD_GCD_SWAP;
            ST_EVAL:          if (status.g_is_one) cmd = CMD_ADVANCE;
            ST_FIN_SMALL:     if (!status.out_busy) cmd = CMD_RESULT_SMALL;
            ST_FIN_CAP:       if (!status.out_busy) cmd = CMD_RESULT_CAP;
            ST_FIN_FAC:       if (!status.out_busy) cmd = CMD_RESULT_FAC;
            default:          cmd = CMD_NONE;
        endcase
    end

endmodule

### rtl/core/rpf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_datapath
// Generator, modular square, shared divider, gcd registers and result register.
// ----------------------------------------------------------------------------
module rpf_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rpf_pkg::cmd_t              cmd,
    output rpf_pkg::dp_status_t        status,
    input  logic [63:0]                s_composite,
    input  logic                       cfg_valid,
    input  logic [1:0]                 cfg_index,
    input  logic [31:0]                cfg_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [31:0]                m_small_factor,
    output logic [31:0]                m_large_factor,
    output logic [1:0]                 m_status,
    output logic [31:0]                m_step_count
);
    import rpf_pkg::*;

    localparam int W = WORD_BITS;

    logic [31:0]       limit_reg;
    logic [GEN_W-1:0]  gen_reg;
    logic [GEN_W-1:0]  lcg_acc_reg;
    logic [GEN_W-1:0]  lcg_add_reg;
    logic [GCNT_W-1:0] lcg_cnt_reg;
    logic [GEN_W-1:0]  lcg_acc_next;

    logic [W-1:0]      n_reg;
    logic [W-1:0]      q_reg;
    logic [W-1:0]      x_reg;
    logic [W-1:0]      y_reg;
    logic [31:0]       j_reg;
    logic [31:0]       steps_reg;

    logic [W-1:0]      acc_reg;
    logic [W-1:0]      dbl_reg;
    logic [W-1:0]      bits_reg;

    logic [W-1:0]      ga_reg;
    logic [W-1:0]      gb_reg;

    logic [DIVD_W-1:0] quot_reg;
    logic [W:0]        rem_reg;
    logic [W-1:0]      dvs_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [W:0]        rem_shift;

    logic              m_valid_reg;
    logic [31:0]       small_reg;
    logic [31:0]       large_reg;
    logic [1:0]        status_reg;
    logic [31:0]       count_reg;

    logic [30:0]       draw;
    logic [W-1:0]      z_val;
    logic [W-1:0]      other;
    logic [W-1:0]      lo_val;
    logic [W-1:0]      hi_val;
    logic              hi_wide;

    function automatic logic [W-1:0] r_q_dividend(input logic [30:0] r);
        return W'(r[3:0]) + W'(17);
    endfunction

    assign draw         = gen_reg[GEN_W-1:17];
    assign lcg_acc_next = GEN_MUL[lcg_cnt_reg] ? (lcg_acc_reg + lcg_add_reg) : lcg_acc_reg;
    assign rem_shift    = {rem_reg[W-1:0], quot_reg[DIVD_W-1]};
    assign z_val        = (acc_reg < y_reg) ? (acc_reg - y_reg + n_reg) : (acc_reg - y_reg);
    assign other        = quot_reg[W-1:0];
    assign lo_val       = (ga_reg < other) ? ga_reg : other;
    assign hi_val       = (ga_reg < other) ? other : ga_reg;
    assign hi_wide      = 65'(hi_val) > 65'h0_FFFF_FFFF;

    // configuration and generator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RST;
            gen_reg   <= GEN_RST;
        end else begin
            if (cfg_valid && cfg_index == CFG_STEP_LIMIT) begin
                limit_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == CFG_RANDOM_SEED) begin
                gen_reg <= {cfg_data, GEN_LOW};
            end else if (cmd == CMD_LCG_RUN && lcg_cnt_reg == GEN_LAST) begin
                gen_reg <= lcg_acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd == CMD_LCG_START) begin
            lcg_acc_reg <= GEN_ADD;
            lcg_add_reg <= gen_reg;
            lcg_cnt_reg <= '0;
        end else if (cmd == CMD_LCG_RUN) begin
            lcg_acc_reg <= lcg_acc_next;
            lcg_add_reg <= {lcg_add_reg[GEN_W-2:0], 1'b0};
            lcg_cnt_reg <= lcg_cnt_reg + 1'b1;
        end
    end

    // shared restoring divider
    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_DIV_Q: begin
                quot_reg <= DIVD_W'(r_q_dividend(draw));
                dvs_reg  <= n_reg;
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            CMD_DIV_X: begin
                quot_reg <= DIVD_W'(draw);
                dvs_reg  <= n_reg - 1'b1;
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            CMD_DIV_GCD: begin
                quot_reg <= DIVD_W'(ga_reg);
                dvs_reg  <= gb_reg;
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            CMD_DIV_FAC: begin
                quot_reg <= DIVD_W'(n_reg);
                dvs_reg  <= ga_reg;
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            CMD_DIV_RUN: begin
                if (rem_shift >= {1'b0, dvs_reg}) begin
                    rem_reg  <= rem_shift - {1'b0, dvs_reg};
                    quot_reg <= {quot_reg[DIVD_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_shift;
                    quot_reg <= {quot_reg[DIVD_W-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // rho state, modular square and gcd operands
    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_LOAD: begin
                n_reg     <= s_composite[W-1:0];
                steps_reg <= '0;
            end
            CMD_SET_Q: q_reg <= rem_reg[W-1:0];
            CMD_SET_X: begin
                x_reg <= rem_reg[W-1:0] + 1'b1;
                y_reg <= rem_reg[W-1:0] + 1'b1;
                j_reg <= 32'd1;
            end
            CMD_MAP_START: begin
                steps_reg <= steps_reg + 1'b1;
                acc_reg   <= q_reg;
                dbl_reg   <= x_reg;
                bits_reg  <= x_reg;
            end
            CMD_MAP_RUN: begin
                if (bits_reg != '0) begin
                    if (bits_reg[0]) acc_reg <= add_mod(acc_reg, dbl_reg, n_reg);
                    dbl_reg  <= add_mod(dbl_reg, dbl_reg, n_reg);
                    bits_reg <= bits_reg >> 1;
                end
            end
            CMD_DIFF: begin
                x_reg  <= acc_reg;
                ga_reg <= z_val;
                gb_reg <= n_reg;
            end
            CMD_GCD_SWAP: begin
                ga_reg <= gb_reg;
                gb_reg <= rem_reg[W-1:0];
            end
            CMD_ADVANCE: begin
                if ((j_reg & (j_reg - 1'b1)) == '0) y_reg <= x_reg;
                j_reg <= j_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd == CMD_RESULT_SMALL || cmd == CMD_RESULT_CAP
                     || cmd == CMD_RESULT_FAC) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_RESULT_SMALL: begin
                small_reg  <= '0;
                large_reg  <= '0;
                status_reg <= STATUS_RANGE;
                count_reg  <= '0;
            end
            CMD_RESULT_CAP: begin
                small_reg  <= '0;
                large_reg  <= '0;
                status_reg <= STATUS_CAPPED;
                count_reg  <= steps_reg;
            end
            CMD_RESULT_FAC: begin
                small_reg  <= hi_wide ? 32'd0 : 32'(lo_val);
                large_reg  <= hi_wide ? 32'd0 : 32'(hi_val);
                status_reg <= hi_wide ? STATUS_RANGE : STATUS_OK;
                count_reg  <= steps_reg;
            end
            default: ;
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_small_factor = small_reg;
    assign m_large_factor = large_reg;
    assign m_status       = status_reg;
    assign m_step_count   = count_reg;

    always_comb begin
        status.n_small    = n_reg < W'(4);
        status.lcg_last   = lcg_cnt_reg == GEN_LAST;
        status.div_last   = dcnt_reg == DIV_LAST;
        status.map_done   = bits_reg == '0;
        status.capped     = steps_reg >= limit_reg;
        status.gcd_b_zero = gb_reg == '0;
        status.g_is_one   = ga_reg == W'(1);
        status.g_lt_n     = ga_reg < n_reg;
        status.out_busy   = m_valid_reg && !m_ready;
    end

endmodule

### rtl/core/pollard_rho_semiprime_factor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pollard_rho_semiprime_factor_unit
// Splits a composite of up to 64 bits by Pollard rho with Brent-style
// reference refresh, bit-serial modular squaring and Euclid gcd.
// ----------------------------------------------------------------------------
// usage
//   s_valid/s_ready/s_composite: one composite per transaction, taken only
//   while the unit is idle
//   m_valid/m_ready: one result per composite with both factors (smaller
//   first), a status code and the number of rho steps taken
//   cfg_valid/cfg_ready/cfg_index/cfg_data: index 0 step limit, index 1
//   random seed; cfg_ready is always high, write only while idle
// operation
//   each draw runs the serial generator, then a divide and a store;
//   each rho step runs the double-and-add unit, then one divide per Euclid
//   remainder in the shared one-bit-per-cycle divider
//   inputs below 4 skip the search and return a range status
// reset
//   aresetn clears the controller and output valid, loads step limit
//   16777216 and the default generator state
// stall
//   a held result blocks the next result; the next composite is taken once
//   the pending result has been loaded into the output register
// ----------------------------------------------------------------------------
module pollard_rho_semiprime_factor_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_composite,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_small_factor,
    output logic [31:0] m_large_factor,
    output logic [1:0]  m_status,
    output logic [31:0] m_step_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import rpf_pkg::*;

    cmd_t       cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    rpf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rpf_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_composite    (s_composite),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_small_factor (m_small_factor),
        .m_large_factor (m_large_factor),
        .m_status       (m_status),
        .m_step_count   (m_step_count)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> m_small_factor == '0 && m_large_factor == '0)
        else $error("failed result carries factors");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_OK |-> m_small_factor <= m_large_factor
                                             && m_small_factor > 32'd1)
        else $error("factors out of order");

    a_small_no_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        u_datapath.status.n_small && cmd == CMD_RESULT_SMALL |=> m_step_count == '0)
        else $error("small input reports steps");

endmodule
